// ----- design/b2r_pkg.sv -----
// ----------------------------------------------------------------------------
// b2r_pkg
// Shared types and constants for the 24-bit bitmap to RGB565 bus writer.
// ----------------------------------------------------------------------------
package b2r_pkg;

	// Parser phases.
	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_SEEK   = 2'd1,
		PH_DATA   = 2'd2,
		PH_IDLE   = 2'd3
	} phase_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_SCREEN_WIDTH  = 2'd0,
		REG_SCREEN_HEIGHT = 2'd1,
		REG_COLUMN_OFFSET = 2'd2,
		REG_ROW_OFFSET    = 2'd3
	} reg_index_t;

	// Controller command indexes.
	localparam logic [15:0] CMD_HWIN  = 16'h0044;
	localparam logic [15:0] CMD_VWIN  = 16'h0045;
	localparam logic [15:0] CMD_ADDR  = 16'h0021;
	localparam logic [15:0] CMD_WRITE = 16'h0022;

	// Header layout.
	localparam logic [31:0] HDR_LEN     = 32'd34;
	localparam logic [15:0] BMP_PLANES  = 16'd1;
	localparam logic [15:0] BMP_DEPTH   = 16'd24;

	// Slot of the pixel word in a result burst, and of the last command.
	localparam logic [2:0] SLOT_LAST_CMD = 3'd6;
	localparam logic [2:0] SLOT_PIXEL    = 3'd7;

endpackage

// ----- design/bmp24_to_rgb565_lcd_writer.sv -----
// ----------------------------------------------------------------------------
// bmp24_to_rgb565_lcd_writer
// Parses a 24-bit bitmap byte stream and issues LCD window commands and
// RGB565 pixel writes, centring and clipping the image on the screen.
// ----------------------------------------------------------------------------
// The first result of a byte appears in the cycle after it is accepted.
// Throughput: one byte per cycle while out_stall is low and each byte gives at
// most one result; a byte that opens a drawn row gives seven results and holds
// the input while the burst drains through the result buffer.
// Reset: arst_n clears the parser and loads the screen size defaults 176x220.
module bmp24_to_rgb565_lcd_writer #(
	parameter int MAX_IMAGE_WIDTH = 1280
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data,
	// byte input
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        restart,
	input  logic [7:0]  file_byte,
	// bus write output
	output logic        out_valid,
	input  logic        out_stall,
	output logic        is_command,
	output logic [15:0] bus_word,
	output logic        rejected,
	output logic        image_done,
	output logic        last_of_run
);

	localparam int SW = $clog2(MAX_IMAGE_WIDTH * 3 + 4);
	localparam logic [31:0] MAX_W = 32'(MAX_IMAGE_WIDTH);

	// Configuration registers.
	logic [8:0] scr_w_q, scr_h_q;
	logic [7:0] col_ofs_q, row_ofs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr_w_q   <= 9'd176;
			scr_h_q   <= 9'd220;
			col_ofs_q <= 8'd0;
			row_ofs_q <= 8'd0;
		end else if (cfg_we) begin
			case (b2r_pkg::reg_index_t'(cfg_index))
				b2r_pkg::REG_SCREEN_WIDTH:  scr_w_q   <= cfg_data;
				b2r_pkg::REG_SCREEN_HEIGHT: scr_h_q   <= cfg_data;
				b2r_pkg::REG_COLUMN_OFFSET: col_ofs_q <= cfg_data[7:0];
				b2r_pkg::REG_ROW_OFFSET:    row_ofs_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Parser state.
	b2r_pkg::phase_t phase_q, phase_d;
	logic [31:0] pos_q, pos_d;
	logic [31:0] ofs_q, ofs_d;
	logic [31:0] img_w_q, img_w_d;
	logic [31:0] img_h_q, img_h_d;
	logic [31:0] pd_q, pd_d;
	logic [31:0] comp_q, comp_d;
	logic [SW-1:0] stride_q, stride_d;
	logic [SW-1:0] bir_q, bir_d;
	logic [1:0]  sub_q, sub_d;
	logic [31:0] skip_q, skip_d;
	logic [7:0]  xs_q, xs_d, xe_q, xe_d, ys_q, ys_d;
	logic [7:0]  row_q, row_d;
	logic [8:0]  vis_q, vis_d;
	logic [10:0] vis3_q, vis3_d;
	logic [15:0] partial_q, partial_d;

	// Result burst produced by the current byte.
	logic        gen_rej, gen_cmd, gen_pix, gen_done;
	logic [15:0] gen_word;

	// Result buffer.
	logic        ob_valid_q;
	logic [2:0]  ob_idx_q, ob_last_q;
	logic        ob_rej_q, ob_done_q;
	logic [15:0] ob_pix_q;

	logic in_fire, out_fire, ob_free;

	assign out_fire = out_valid && !out_stall;
	assign ob_free  = out_fire && (ob_idx_q == ob_last_q);
	assign in_stall = ob_valid_q && !ob_free;
	assign in_fire  = in_valid && !in_stall;

	// Effective state after an optional restart, and the byte decode.
	logic [31:0] pos_e, ofs_e, w_e, h_e, pd_e, comp_e;
	b2r_pkg::phase_t phase_e;
	logic [31:0] comp_full;
	logic        hdr_ok;
	logic [8:0]  sw_c, sh_c;
	logic        w_gt, h_gt, do_data;
	logic [SW-1:0] bir_inc;

	always_comb begin
		phase_e = restart ? b2r_pkg::PH_HEADER : phase_q;
		pos_e   = restart ? 32'd0 : pos_q;
		ofs_e   = restart ? 32'd0 : ofs_q;
		w_e     = restart ? 32'd0 : img_w_q;
		h_e     = restart ? 32'd0 : img_h_q;
		pd_e    = restart ? 32'd0 : pd_q;
		comp_e  = restart ? 32'd0 : comp_q;

		sw_c = (scr_w_q == 9'd0) ? 9'd1 : ((scr_w_q > 9'd256) ? 9'd256 : scr_w_q);
		sh_c = (scr_h_q == 9'd0) ? 9'd1 : ((scr_h_q > 9'd256) ? 9'd256 : scr_h_q);
		w_gt = w_e > {23'd0, sw_c};
		h_gt = h_e > {23'd0, sh_c};

		comp_full = {file_byte, comp_e[23:0]};
		hdr_ok = (pd_e[15:0] == b2r_pkg::BMP_PLANES) && (pd_e[31:16] == b2r_pkg::BMP_DEPTH)
			&& (comp_full == 32'd0) && (w_e != 32'd0) && (w_e <= MAX_W) && (h_e != 32'd0);

		bir_inc = bir_q + 1'b1;

		phase_d   = phase_e;
		pos_d     = (pos_e == 32'hFFFF_FFFF) ? pos_e : pos_e + 32'd1;
		ofs_d     = ofs_e;
		img_w_d   = w_e;
		img_h_d   = h_e;
		pd_d      = pd_e;
		comp_d    = comp_e;
		stride_d  = stride_q;
		bir_d     = bir_q;
		sub_d     = sub_q;
		skip_d    = skip_q;
		xs_d      = xs_q;
		xe_d      = xe_q;
		ys_d      = ys_q;
		row_d     = row_q;
		vis_d     = vis_q;
		vis3_d    = vis3_q;
		partial_d = partial_q;
		gen_rej   = 1'b0;
		gen_cmd   = 1'b0;
		gen_pix   = 1'b0;
		gen_done  = 1'b0;
		gen_word  = 16'd0;
		do_data   = 1'b0;

		case (phase_e)
			b2r_pkg::PH_HEADER: begin
				// Gather the little-endian header words.
				if (pos_e < b2r_pkg::HDR_LEN) begin
					case (pos_e[5:0])
						6'd10: ofs_d[7:0]    = ofs_e[7:0] | file_byte;
						6'd11: ofs_d[15:8]   = ofs_e[15:8] | file_byte;
						6'd12: ofs_d[23:16]  = ofs_e[23:16] | file_byte;
						6'd13: ofs_d[31:24]  = ofs_e[31:24] | file_byte;
						6'd18: img_w_d[7:0]  = w_e[7:0] | file_byte;
						6'd19: img_w_d[15:8] = w_e[15:8] | file_byte;
						6'd20: img_w_d[23:16] = w_e[23:16] | file_byte;
						6'd21: img_w_d[31:24] = w_e[31:24] | file_byte;
						6'd22: img_h_d[7:0]  = h_e[7:0] | file_byte;
						6'd23: img_h_d[15:8] = h_e[15:8] | file_byte;
						6'd24: img_h_d[23:16] = h_e[23:16] | file_byte;
						6'd25: img_h_d[31:24] = h_e[31:24] | file_byte;
						6'd26: pd_d[7:0]     = pd_e[7:0] | file_byte;
						6'd27: pd_d[15:8]    = pd_e[15:8] | file_byte;
						6'd28: pd_d[23:16]   = pd_e[23:16] | file_byte;
						6'd29: pd_d[31:24]   = pd_e[31:24] | file_byte;
						6'd30: comp_d[7:0]   = comp_e[7:0] | file_byte;
						6'd31: comp_d[15:8]  = comp_e[15:8] | file_byte;
						6'd32: comp_d[23:16] = comp_e[23:16] | file_byte;
						6'd33: comp_d[31:24] = comp_e[31:24] | file_byte;
						default: ;
					endcase
				end
				// Check the header on its last byte and set up the window.
				if (pos_e == b2r_pkg::HDR_LEN - 32'd1) begin
					if (!hdr_ok) begin
						gen_rej = 1'b1;
						phase_d = b2r_pkg::PH_IDLE;
					end else begin
						if (w_gt) begin
							xs_d  = 8'd0;
							xe_d  = 8'(sw_c - 9'd1);
							vis_d = sw_c;
						end else begin
							xs_d  = 8'((sw_c - w_e[8:0]) >> 1);
							xe_d  = 8'(((sw_c - w_e[8:0]) >> 1) + w_e[8:0] - 9'd1);
							vis_d = w_e[8:0];
						end
						if (h_gt) begin
							ys_d   = 8'd0;
							row_d  = 8'(sh_c - 9'd1);
							skip_d = h_e - {23'd0, sh_c};
						end else begin
							ys_d   = 8'((sh_c - h_e[8:0]) >> 1);
							row_d  = 8'(((sh_c - h_e[8:0]) >> 1) + h_e[8:0] - 9'd1);
							skip_d = 32'd0;
						end
						vis3_d   = 11'({2'b00, vis_d} * 11'd3);
						stride_d = SW'((w_e[SW-1:0] * SW'(3) + SW'(3)) & ~SW'(3));
						bir_d    = '0;
						sub_d    = 2'd0;
						ofs_d    = (ofs_e < b2r_pkg::HDR_LEN) ? b2r_pkg::HDR_LEN : ofs_e;
						phase_d  = b2r_pkg::PH_SEEK;
					end
				end
			end
			b2r_pkg::PH_SEEK: begin
				if (pos_e >= ofs_e) begin
					phase_d = b2r_pkg::PH_DATA;
					do_data = 1'b1;
				end
			end
			b2r_pkg::PH_DATA: do_data = 1'b1;
			default: ;
		endcase

		// Pixel data byte.
		if (do_data) begin
			if (skip_q != 32'd0) begin
				if (bir_inc >= stride_q) begin
					bir_d  = '0;
					sub_d  = 2'd0;
					skip_d = skip_q - 32'd1;
				end else begin
					bir_d = bir_inc;
					sub_d = (sub_q == 2'd2) ? 2'd0 : sub_q + 2'd1;
				end
			end else begin
				gen_cmd = (bir_q == '0);
				if (32'(bir_q) < 32'(vis3_q)) begin
					case (sub_q)
						2'd0: partial_d = {11'd0, file_byte[7:3]};
						2'd1: partial_d = partial_q | {5'd0, file_byte[7:2], 5'd0};
						default: begin
							gen_pix  = 1'b1;
							gen_word = partial_q | {file_byte[7:3], 11'd0};
							gen_done = (32'(bir_q) == 32'(vis3_q) - 32'd1) && (row_q <= ys_q);
						end
					endcase
				end
				if (gen_done) begin
					phase_d = b2r_pkg::PH_IDLE;
				end else if (bir_inc >= stride_q) begin
					bir_d = '0;
					sub_d = 2'd0;
					row_d = row_q - 8'd1;
				end else begin
					bir_d = bir_inc;
					sub_d = (sub_q == 2'd2) ? 2'd0 : sub_q + 2'd1;
				end
			end
		end
	end

	// Parser registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= b2r_pkg::PH_HEADER;
			pos_q   <= 32'd0;
			ofs_q   <= 32'd0;
			img_w_q <= 32'd0;
			img_h_q <= 32'd0;
			pd_q    <= 32'd0;
			comp_q  <= 32'd0;
			stride_q <= '0;
			bir_q   <= '0;
			sub_q   <= 2'd0;
			skip_q  <= 32'd0;
			xs_q    <= 8'd0;
			xe_q    <= 8'd0;
			ys_q    <= 8'd0;
			row_q   <= 8'd0;
			vis_q   <= 9'd0;
			vis3_q  <= 11'd0;
		end else if (in_fire) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			ofs_q   <= ofs_d;
			img_w_q <= img_w_d;
			img_h_q <= img_h_d;
			pd_q    <= pd_d;
			comp_q  <= comp_d;
			stride_q <= stride_d;
			bir_q   <= bir_d;
			sub_q   <= sub_d;
			skip_q  <= skip_d;
			xs_q    <= xs_d;
			xe_q    <= xe_d;
			ys_q    <= ys_d;
			row_q   <= row_d;
			vis_q   <= vis_d;
			vis3_q  <= vis3_d;
		end
	end

	// Pixel payload registers.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			partial_q <= partial_d;
			if (gen_pix) begin
				ob_pix_q  <= gen_word;
				ob_done_q <= gen_done;
			end
		end
	end

	// Result buffer control: a burst of commands, a pixel, or a reject.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_valid_q <= 1'b0;
			ob_idx_q   <= 3'd0;
			ob_last_q  <= 3'd0;
			ob_rej_q   <= 1'b0;
		end else if (in_fire && (gen_rej || gen_cmd || gen_pix)) begin
			ob_valid_q <= 1'b1;
			ob_rej_q   <= gen_rej;
			ob_idx_q   <= (gen_rej || gen_cmd) ? 3'd0 : b2r_pkg::SLOT_PIXEL;
			ob_last_q  <= gen_rej ? 3'd0
				: (gen_pix ? b2r_pkg::SLOT_PIXEL : b2r_pkg::SLOT_LAST_CMD);
		end else if (ob_free) begin
			ob_valid_q <= 1'b0;
		end else if (out_fire) begin
			ob_idx_q <= ob_idx_q + 3'd1;
		end
	end

	// Output word selection.
	always_comb begin
		out_valid   = ob_valid_q;
		rejected    = ob_rej_q;
		last_of_run = ob_idx_q == ob_last_q;
		is_command  = 1'b0;
		image_done  = 1'b0;
		bus_word    = 16'd0;
		if (!ob_rej_q) begin
			case (ob_idx_q)
				3'd0: begin is_command = 1'b1; bus_word = b2r_pkg::CMD_HWIN; end
				3'd1: bus_word = {col_ofs_q + xe_q, col_ofs_q + xs_q};
				3'd2: begin is_command = 1'b1; bus_word = b2r_pkg::CMD_VWIN; end
				3'd3: bus_word = {row_ofs_q + row_q, row_ofs_q + row_q};
				3'd4: begin is_command = 1'b1; bus_word = b2r_pkg::CMD_ADDR; end
				3'd5: bus_word = {row_ofs_q + row_q, col_ofs_q + xs_q};
				3'd6: begin is_command = 1'b1; bus_word = b2r_pkg::CMD_WRITE; end
				default: begin
					bus_word   = ob_pix_q;
					image_done = ob_done_q;
				end
			endcase
		end
	end

endmodule

// ----- design/b2r_checker.sv -----
// ----------------------------------------------------------------------------
// b2r_checker
// Port-level assertions for the bitmap to RGB565 bus writer.
// ----------------------------------------------------------------------------
module b2r_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        is_command,
	input logic        rejected,
	input logic        image_done,
	input logic        last_of_run
);

	// A stalled result stays offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A reject is a lone data word.
	a_rej: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rejected |-> last_of_run && !is_command && !image_done)
		else $error("malformed reject result");

	// The final pixel ends its burst and is a data write.
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && image_done |-> last_of_run && !is_command)
		else $error("malformed image end");

	// A command never carries the reject or image end flags.
	a_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_command |-> !rejected && !image_done)
		else $error("command carries a status flag");

endmodule

bind bmp24_to_rgb565_lcd_writer b2r_checker u_b2r_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.is_command  (is_command),
	.rejected    (rejected),
	.image_done  (image_done),
	.last_of_run (last_of_run)
);

// ----- sim/bmp24_to_rgb565_lcd_writer_tb.sv -----
// ----------------------------------------------------------------------------
// bmp24_to_rgb565_lcd_writer_tb
// Streams whole bitmap files into the bus writer under several screen and
// offset settings, predicts every bus write and checks it field by field.
// ----------------------------------------------------------------------------
module bmp24_to_rgb565_lcd_writer_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_W = 1280;
	localparam int QUIET_LIMIT = 200000;
	localparam int HOLD_LEN = 300;

	typedef struct packed {
		logic       restart;
		logic [7:0] fbyte;
	} file_item_t;

	typedef struct packed {
		logic        cmd;
		logic [15:0] word;
		logic        rej;
		logic        done;
		logic        last;
	} bus_write_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [8:0]  cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic        restart;
	logic [7:0]  file_byte;
	logic        out_valid;
	logic        out_stall;
	logic        is_command;
	logic [15:0] bus_word;
	logic        rejected;
	logic        image_done;
	logic        last_of_run;

	bmp24_to_rgb565_lcd_writer dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.restart(restart), .file_byte(file_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.is_command(is_command), .bus_word(bus_word), .rejected(rejected),
		.image_done(image_done), .last_of_run(last_of_run)
	);

	// Items waiting for the driver, and bus writes waiting for the monitor.
	file_item_t pending_bytes[$];
	bus_write_t expected_writes[$];
	int         mismatch_count = 0;
	int         idle_pct = 0;
	int         stall_pct = 0;
	int         hold_cycles = 0;
	int         hold_requests = 0;
	int         hold_served = 0;
	int         quiet_cycles = 0;

	// Shadow of the configuration and of the parser.
	logic [8:0]  sh_width, sh_height;
	logic [7:0]  sh_col_ofs, sh_row_ofs;
	b2r_pkg::phase_t p_phase;
	logic [31:0] p_pos, p_data_ofs, p_img_w, p_img_h, p_planes_depth, p_compr;
	logic [31:0] p_stride, p_in_row, p_skip_rows, p_visible;
	logic [7:0]  p_xs, p_xe, p_ys, p_ye, p_row;
	logic [15:0] p_partial;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] clamp_size(input logic [8:0] v);
		if (v == 0)
			return 1;
		if (v > 256)
			return 256;
		return v;
	endfunction

	task automatic clear_parser();
		p_phase = b2r_pkg::PH_HEADER;
		p_pos = 0; p_data_ofs = 0; p_img_w = 0; p_img_h = 0;
		p_planes_depth = 0; p_compr = 0; p_stride = 0; p_in_row = 0;
		p_skip_rows = 0; p_visible = 0; p_xs = 0; p_xe = 0; p_ys = 0; p_ye = 0;
		p_row = 0; p_partial = 0;
	endtask

	task automatic push_write(input logic c, input logic [15:0] w, input logic r,
			input logic d);
		bus_write_t bw;
		bw.cmd = c; bw.word = w; bw.rej = r; bw.done = d; bw.last = 1'b0;
		expected_writes.push_back(bw);
	endtask

	// Latch window, clipping and row skip when a good header completes.
	task automatic latch_window();
		logic [31:0] sw, shh, v;
		sw = clamp_size(sh_width);
		shh = clamp_size(sh_height);
		if (p_img_w > sw) begin
			p_xs = 0; p_xe = 8'(sw - 1);
		end else begin
			v = (sw - p_img_w) / 2;
			p_xs = 8'(v); p_xe = 8'(v + p_img_w - 1);
		end
		if (p_img_h > shh) begin
			p_ys = 0; p_ye = 8'(shh - 1);
		end else begin
			v = (shh - p_img_h) / 2;
			p_ys = 8'(v); p_ye = 8'(v + p_img_h - 1);
		end
		p_visible = (p_img_w > sw) ? sw : p_img_w;
		p_stride = (p_img_w * 3 + 3) & ~32'd3;
		p_skip_rows = (p_img_h > shh) ? p_img_h - shh : 0;
		p_row = p_ye;
		p_in_row = 0;
		if (p_data_ofs < b2r_pkg::HDR_LEN)
			p_data_ofs = b2r_pkg::HDR_LEN;
		p_phase = b2r_pkg::PH_SEEK;
	endtask

	// One byte of pixel data: skipped rows, row commands, RGB565 packing.
	task automatic pixel_byte(input logic [7:0] b);
		logic [31:0] k;
		logic [15:0] px;
		logic        last_px;
		k = p_in_row;
		if (p_skip_rows != 0) begin
			p_in_row++;
			if (p_in_row >= p_stride) begin
				p_in_row = 0;
				p_skip_rows--;
			end
			return;
		end
		if (k == 0) begin
			push_write(1'b1, b2r_pkg::CMD_HWIN, 1'b0, 1'b0);
			push_write(1'b0, {sh_col_ofs + p_xe, sh_col_ofs + p_xs}, 1'b0, 1'b0);
			push_write(1'b1, b2r_pkg::CMD_VWIN, 1'b0, 1'b0);
			push_write(1'b0, {sh_row_ofs + p_row, sh_row_ofs + p_row}, 1'b0, 1'b0);
			push_write(1'b1, b2r_pkg::CMD_ADDR, 1'b0, 1'b0);
			push_write(1'b0, {sh_row_ofs + p_row, sh_col_ofs + p_xs}, 1'b0, 1'b0);
			push_write(1'b1, b2r_pkg::CMD_WRITE, 1'b0, 1'b0);
		end
		if (k < p_visible * 3) begin
			case (k % 3)
				0: p_partial = 16'(b >> 3);
				1: p_partial = p_partial | (16'(b >> 2) << 5);
				default: begin
					px = p_partial | (16'(b >> 3) << 11);
					last_px = (k == p_visible * 3 - 1) && (p_row <= p_ys);
					push_write(1'b0, px, 1'b0, last_px);
					if (last_px) begin
						p_phase = b2r_pkg::PH_IDLE;
						return;
					end
				end
			endcase
		end
		p_in_row++;
		if (p_in_row >= p_stride) begin
			p_in_row = 0;
			p_row = p_row - 8'd1;
		end
	endtask

	// Work out the bus writes caused by one accepted byte.
	task automatic predict_writes(input file_item_t it);
		int n0;
		logic [31:0] pos, b;
		bus_write_t  tail;
		n0 = expected_writes.size();
		if (it.restart)
			clear_parser();
		pos = p_pos;
		b = 32'(it.fbyte);
		case (p_phase)
			b2r_pkg::PH_HEADER: begin
				if (pos >= 10 && pos < 14)
					p_data_ofs |= b << (8 * (pos - 10));
				else if (pos >= 18 && pos < 22)
					p_img_w |= b << (8 * (pos - 18));
				else if (pos >= 22 && pos < 26)
					p_img_h |= b << (8 * (pos - 22));
				else if (pos >= 26 && pos < 30)
					p_planes_depth |= b << (8 * (pos - 26));
				else if (pos >= 30 && pos < 34)
					p_compr |= b << (8 * (pos - 30));
				if (pos == b2r_pkg::HDR_LEN - 1) begin
					if (p_planes_depth[15:0] != b2r_pkg::BMP_PLANES
							|| p_planes_depth[31:16] != b2r_pkg::BMP_DEPTH
							|| p_compr != 0 || p_img_w == 0 || p_img_w > MAX_W
							|| p_img_h == 0) begin
						push_write(1'b0, 16'h0000, 1'b1, 1'b0);
						p_phase = b2r_pkg::PH_IDLE;
					end else begin
						latch_window();
					end
				end
			end
			b2r_pkg::PH_SEEK: begin
				if (pos >= p_data_ofs) begin
					p_phase = b2r_pkg::PH_DATA;
					pixel_byte(it.fbyte);
				end
			end
			b2r_pkg::PH_DATA: pixel_byte(it.fbyte);
			default: ;
		endcase
		if (p_pos != 32'hFFFF_FFFF)
			p_pos++;
		if (expected_writes.size() > n0) begin
			tail = expected_writes.pop_back();
			tail.last = 1'b1;
			expected_writes.push_back(tail);
		end
	endtask

	// Queue a complete file; fields can be forced bad to hit every reject.
	// A file whose header is rejected carries no pixel body.
	task automatic queue_file(input int w, input int h, input int data_ofs,
			input int planes, input int depth, input int compr, input int gap_bytes,
			input int trail_bytes);
		logic [7:0] hdr[34];
		int stride;
		int body;
		logic good;
		file_item_t it;
		for (int i = 0; i < 34; i++)
			hdr[i] = 8'($urandom);
		for (int i = 0; i < 4; i++) begin
			hdr[10 + i] = 8'(data_ofs >> (8 * i));
			hdr[18 + i] = 8'(w >> (8 * i));
			hdr[22 + i] = 8'(h >> (8 * i));
			hdr[30 + i] = 8'(compr >> (8 * i));
		end
		hdr[26] = 8'(planes); hdr[27] = 8'(planes >> 8);
		hdr[28] = 8'(depth); hdr[29] = 8'(depth >> 8);
		for (int i = 0; i < 34; i++) begin
			it.restart = (i == 0);
			it.fbyte = hdr[i];
			pending_bytes.push_back(it);
		end
		good = (planes == 1) && (depth == 24) && (compr == 0) && (w >= 1)
			&& (w <= MAX_W) && (h != 0);
		stride = (w * 3 + 3) & ~3;
		body = good ? stride * h + trail_bytes : trail_bytes;
		for (int i = 0; i < gap_bytes; i++) begin
			it.restart = 1'b0;
			it.fbyte = 8'($urandom);
			pending_bytes.push_back(it);
		end
		for (int i = 0; i < body; i++) begin
			it.restart = 1'b0;
			it.fbyte = 8'($urandom);
			pending_bytes.push_back(it);
		end
	endtask

	// A good file with data right after the header or after a gap.
	task automatic queue_good(input int w, input int h);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
		queue_file(w, h, 34 + gap, 1, 24, 0, gap, $urandom_range(0, 3));
	endtask

	task automatic wait_drained();
		while (pending_bytes.size() != 0 || expected_writes.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input b2r_pkg::reg_index_t idx, input logic [8:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			b2r_pkg::REG_SCREEN_WIDTH: sh_width = val;
			b2r_pkg::REG_SCREEN_HEIGHT: sh_height = val;
			b2r_pkg::REG_COLUMN_OFFSET: sh_col_ofs = val[7:0];
			default: sh_row_ofs = val[7:0];
		endcase
	endtask

	// Driver: offer the next byte, hold it while stalled.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			restart <= 1'b0;
			file_byte <= 8'h00;
		end else begin
			if (in_valid && !in_stall) begin
				predict_writes('{restart: restart, fbyte: file_byte});
				void'(pending_bytes.pop_front());
			end
			if (in_valid && in_stall) begin
				// hold the offered byte
			end else if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
				in_valid <= 1'b1;
				restart <= pending_bytes[0].restart;
				file_byte <= pending_bytes[0].fbyte;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Long receiver hold-off, counted down cycle by cycle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cycles <= 0;
			hold_served <= 0;
		end else if (hold_requests != hold_served) begin
			hold_cycles <= HOLD_LEN;
			hold_served <= hold_requests;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
		end
	end

	// Monitor: compare each accepted bus write with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		bus_write_t got, exp_w;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				got = '{cmd: is_command, word: bus_word, rej: rejected,
					done: image_done, last: last_of_run};
				if (expected_writes.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected bus write %p", got);
				end else begin
					exp_w = expected_writes.pop_front();
					if (got !== exp_w) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("bus write mismatch: expected %p, got %p", exp_w, got);
					end
				end
			end
			if (hold_cycles > 0)
				out_stall <= 1'b1;
			else
				out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// Watchdog on cycles without any handshake.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		int w, h;
		cfg_we = 1'b0; cfg_index = b2r_pkg::REG_SCREEN_WIDTH; cfg_data = 9'd0;
		sh_width = 9'd176; sh_height = 9'd220; sh_col_ofs = 8'd0; sh_row_ofs = 8'd0;
		clear_parser();
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, with no idling: tiny screen, every reject reason, clipping
		// both ways.
		write_reg(b2r_pkg::REG_SCREEN_WIDTH, 9'd4);
		write_reg(b2r_pkg::REG_SCREEN_HEIGHT, 9'd3);
		write_reg(b2r_pkg::REG_COLUMN_OFFSET, 9'd255);
		write_reg(b2r_pkg::REG_ROW_OFFSET, 9'd254);
		queue_file(1, 1, 0, 1, 24, 0, 0, 2);
		queue_file(2, 2, 34, 2, 24, 0, 0, 0);
		queue_file(2, 2, 34, 1, 16, 0, 0, 0);
		queue_file(2, 2, 34, 1, 24, 1, 0, 0);
		queue_file(0, 2, 34, 1, 24, 0, 0, 0);
		queue_file(MAX_W + 1, 2, 34, 1, 24, 0, 0, 0);
		queue_file(2, 0, 34, 1, 24, 0, 0, 0);
		queue_file(5, 4, 38, 1, 24, 0, 4, 0);
		wait_drained();

		// Random phases with different settings and idling patterns.
		for (int ph = 1; ph < 4; ph++) begin
			case (ph)
				1: begin idle_pct = 64; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 64; end
				default: begin idle_pct = 8; stall_pct = 8; end
			endcase
			if (ph == 3) begin
				// Zero and oversize screen settings act as the nearest legal size.
				write_reg(b2r_pkg::REG_SCREEN_WIDTH, 9'd0);
				write_reg(b2r_pkg::REG_SCREEN_HEIGHT, 9'd511);
			end else begin
				write_reg(b2r_pkg::REG_SCREEN_WIDTH, 9'($urandom_range(1, 8)));
				write_reg(b2r_pkg::REG_SCREEN_HEIGHT, 9'($urandom_range(1, 6)));
			end
			write_reg(b2r_pkg::REG_COLUMN_OFFSET, 9'($urandom_range(0, 255)));
			write_reg(b2r_pkg::REG_ROW_OFFSET, 9'($urandom_range(0, 255)));
			if (ph == 2)
				hold_requests++;
			w = $urandom_range(1, 3);
			h = $urandom_range(1, 3);
			if (ph != 2 && $urandom_range(0, 5) == 0)
				queue_file(w, h, 34, 1, 24, $urandom_range(0, 1), 0, 0);
			else
				queue_good(w, h);
			wait_drained();
		end

		if (mismatch_count == 0 && expected_writes.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
design/b2r_pkg.sv
design/bmp24_to_rgb565_lcd_writer.sv
design/b2r_checker.sv
sim/bmp24_to_rgb565_lcd_writer_tb.sv
